/* hdl/its_pkg.sv */
// its_pkg: shared types, character codes and calendar helper for the timestamp validator.
// Used by its_parser and iso_timestamp_validator; depends on nothing.
`timescale 1ns / 1ps

package its_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_T     = 8'h54;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	localparam logic [4:0] POS_DASH1  = 5'd4;
	localparam logic [4:0] POS_DASH2  = 5'd7;
	localparam logic [4:0] POS_T      = 5'd10;
	localparam logic [4:0] POS_COLON1 = 5'd13;
	localparam logic [4:0] POS_COLON2 = 5'd16;
	localparam logic [4:0] POS_CENT   = 5'd2;
	localparam logic [4:0] LEN_DATE   = 5'd10;
	localparam logic [4:0] LEN_FULL   = 5'd19;
	localparam logic [4:0] LEN_SAT    = 5'd20;

	localparam logic [6:0] MAX_HOUR   = 7'd23;
	localparam logic [6:0] MAX_MINSEC = 7'd59;
	localparam logic [6:0] MAX_MONTH  = 7'd12;

	localparam logic [0:0] REG_REQUIRE_TIME = 1'b0;

	// finished string as seen at its last character
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [4:0]  len;
		logic        fmt_err;
		logic [1:0]  cent_mod4;    // century digits mod 4
		logic        low_nonzero;  // last two year digits are not both 0
	} its_snap_t;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		unique case (m)
			4'd2:                       r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
			default:                    r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

/* hdl/its_parser.sv */
// its_parser: per-character field accumulation, separator checks and length count.
// Depends on its_pkg; gives the final snapshot combinationally for the word flagged last.
`timescale 1ns / 1ps

module its_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          char_code,
	input  logic                last_char,
	input  logic                require_time,
	output its_pkg::its_snap_t  snap
);

	its_pkg::its_snap_t st_q;
	its_pkg::its_snap_t nx;
	logic [4:0] pos;
	logic       digit;
	logic [3:0] d;
	logic       checked;
	logic       is_sep;
	logic [7:0] sep;

	assign pos   = st_q.len;
	assign digit = (char_code >= its_pkg::CHAR_ZERO) && (char_code <= its_pkg::CHAR_NINE);
	assign d     = digit ? 4'(char_code - its_pkg::CHAR_ZERO) : 4'd0;
	assign checked = (pos < its_pkg::LEN_DATE) || ((pos < its_pkg::LEN_FULL) && require_time);

	always_comb begin
		is_sep = 1'b1;
		sep    = its_pkg::CHAR_DASH;
		priority if (pos == its_pkg::POS_DASH1 || pos == its_pkg::POS_DASH2) begin
			sep = its_pkg::CHAR_DASH;
		end else if (pos == its_pkg::POS_T) begin
			sep = its_pkg::CHAR_T;
		end else if (pos == its_pkg::POS_COLON1 || pos == its_pkg::POS_COLON2) begin
			sep = its_pkg::CHAR_COLON;
		end else begin
			is_sep = 1'b0;
		end
	end

	always_comb begin
		nx = st_q;
		if (pos < its_pkg::LEN_FULL) begin
			if (!is_sep) begin
				if (digit) begin
					priority if (pos < its_pkg::POS_DASH1) begin
						nx.year = 14'(st_q.year * 14'd10 + 14'(d));
						if (pos < its_pkg::POS_CENT) begin
							nx.cent_mod4 = 2'({st_q.cent_mod4[0], 1'b0} + d[1:0]);
						end else begin
							nx.low_nonzero = st_q.low_nonzero || (d != 4'd0);
						end
					end else if (pos < its_pkg::POS_DASH2) begin
						nx.month = 7'(st_q.month * 7'd10 + 7'(d));
					end else if (pos < its_pkg::POS_T) begin
						nx.day = 7'(st_q.day * 7'd10 + 7'(d));
					end else if (pos < its_pkg::POS_COLON1) begin
						nx.hour = 7'(st_q.hour * 7'd10 + 7'(d));
					end else if (pos < its_pkg::POS_COLON2) begin
						nx.minute = 7'(st_q.minute * 7'd10 + 7'(d));
					end else begin
						nx.second = 7'(st_q.second * 7'd10 + 7'(d));
					end
				end else if (checked) begin
					nx.fmt_err = 1'b1;
				end
			end else if (checked && char_code != sep) begin
				nx.fmt_err = 1'b1;
			end
		end
		if (pos < its_pkg::LEN_SAT) begin
			nx.len = 5'(pos + 5'd1);
		end
	end

	assign snap = nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			if (last_char) begin
				st_q <= '0;
			end else begin
				st_q <= nx;
			end
		end
	end

endmodule

/* hdl/iso_timestamp_validator.sv */
// iso_timestamp_validator: top level with APB register, snapshot stage and result register.
// Depends on its_pkg and its_parser.
// Throughput: one character word per cycle; input stalls only while a finished string
// waits in the snapshot stage behind a stalled result word.
// Last character fills the snapshot stage; out_valid rises once the result register loads.
// Reset clears the parser state and both stage valids; require_time resets to 1.
`timescale 1ns / 1ps

module iso_timestamp_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic [13:0] year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out
);

	logic               require_time_q;
	logic               in_acc;
	logic               s1_valid_q;
	logic               s1_full_s1;
	its_pkg::its_snap_t s1_snap_s1;
	its_pkg::its_snap_t snap;
	logic               out_load;
	logic               leap;
	logic [4:0]         mdays;
	logic               date_ok;
	logic               time_ok;
	logic               len_ok;
	logic               ok;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == its_pkg::REG_REQUIRE_TIME) ? {31'd0, require_time_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			require_time_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[2] == its_pkg::REG_REQUIRE_TIME) begin
			require_time_q <= pwdata[0];
		end
	end

	// handshake
	assign out_load = s1_valid_q && (!out_valid || !out_stall);
	assign in_stall = s1_valid_q && !out_load;
	assign in_acc   = in_valid && !in_stall;

	its_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_acc),
		.char_code    (char_code),
		.last_char    (last_char),
		.require_time (require_time_q),
		.snap         (snap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc && last_char) begin
			s1_valid_q <= 1'b1;
		end else if (out_load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && last_char) begin
			s1_snap_s1 <= snap;
			s1_full_s1 <= require_time_q;
		end
	end

	// checks
	assign leap  = !s1_snap_s1.low_nonzero ? (s1_snap_s1.cent_mod4 == 2'd0)
	                                       : (s1_snap_s1.year[1:0] == 2'd0);
	assign mdays = its_pkg::month_days(s1_snap_s1.month[3:0], leap);
	assign date_ok = (s1_snap_s1.year != 14'd0) && (s1_snap_s1.month != 7'd0)
		&& (s1_snap_s1.month <= its_pkg::MAX_MONTH) && (s1_snap_s1.day != 7'd0)
		&& (s1_snap_s1.day <= {2'b00, mdays});
	assign time_ok = (s1_snap_s1.hour <= its_pkg::MAX_HOUR)
		&& (s1_snap_s1.minute <= its_pkg::MAX_MINSEC)
		&& (s1_snap_s1.second <= its_pkg::MAX_MINSEC);
	assign len_ok = s1_full_s1 ? (s1_snap_s1.len == its_pkg::LEN_FULL)
		: (s1_snap_s1.len == its_pkg::LEN_DATE || s1_snap_s1.len == its_pkg::LEN_FULL);
	assign ok = !s1_snap_s1.fmt_err && len_ok && date_ok && (!s1_full_s1 || time_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			valid_res  <= ok;
			year_out   <= ok ? s1_snap_s1.year : 14'd0;
			month_out  <= ok ? s1_snap_s1.month[3:0] : 4'd0;
			day_out    <= ok ? s1_snap_s1.day[4:0] : 5'd0;
			hour_out   <= (ok && s1_full_s1) ? s1_snap_s1.hour[4:0] : 5'd0;
			minute_out <= (ok && s1_full_s1) ? s1_snap_s1.minute[5:0] : 6'd0;
			second_out <= (ok && s1_full_s1) ? s1_snap_s1.second[5:0] : 6'd0;
		end
	end

endmodule
